FILE: sv/ubdc_pkg.sv
// Package for the UART baud divisor calculator: widths, register indexes,
// the fixed reference clock and the divider stage record.
// Depends on nothing; used by every module of the block.
`default_nettype none
package ubdc_pkg;

	localparam int unsigned BAUD_W = 24;
	localparam int unsigned CLK_W  = 27;
	localparam int unsigned QUO_W  = 24;
	localparam int unsigned NUM_W  = CLK_W + 4;
	localparam int unsigned REM_W  = BAUD_W;
	localparam int unsigned MUL_W  = BAUD_W + 16;
	localparam int unsigned CMP_W  = MUL_W + 4;
	localparam int unsigned INT_W  = 16;
	localparam int unsigned FRAC_W = 6;
	localparam int unsigned RND_W  = INT_W + FRAC_W;
	localparam int unsigned ODATA_W = 24;

	localparam logic [CLK_W-1:0] FIXED_CLOCK_HZ = 27'd16000000;
	localparam logic [CLK_W-1:0] SYS_CLOCK_RESET = 27'd16000000;

	localparam logic [1:0] CFG_CLOCK_SOURCE = 2'd0;
	localparam logic [1:0] CFG_SYSTEM_CLOCK = 2'd1;
	localparam logic [1:0] CFG_SMART_CARD   = 2'd2;

	typedef struct packed {
		logic              zero;
		logic              force16;
		logic              too_large;
		logic [BAUD_W-1:0] baud;
		logic [NUM_W-1:0]  num;
		logic [REM_W-1:0]  rem;
		logic [QUO_W-1:0]  quo;
	} div_t;

endpackage
`default_nettype wire

FILE: sv/ubdc_div_step.sv
// One restoring division step: produces quotient bit BIT of 16*clock/baud.
// Depends on ubdc_pkg for the stage record and widths.
`default_nettype none
module ubdc_div_step #(
	parameter int unsigned BIT = 0
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire ubdc_pkg::div_t in_data,
	output logic              out_valid,
	output ubdc_pkg::div_t    out_data
);
	import ubdc_pkg::*;

	logic [REM_W:0]   trial;
	logic [REM_W+1:0] diff;
	div_t             nxt;

	always_comb begin
		trial = {in_data.rem, in_data.num[BIT]};
		diff  = {1'b0, trial} - {2'b00, in_data.baud};
		nxt   = in_data;
		if (!diff[REM_W+1]) begin
			nxt.rem      = diff[REM_W-1:0];
			nxt.quo[BIT] = 1'b1;
		end else begin
			nxt.rem = trial[REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: sv/ubdc_round_select.sv
// Final stage: rounds the quotient for both oversampling rates, picks one
// and holds the result in the output register. Depends on ubdc_pkg.
`default_nettype none
module ubdc_round_select (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire ubdc_pkg::div_t              in_data,
	output logic                             out_valid,
	output logic                             status,
	output logic                             high_speed,
	output logic [ubdc_pkg::INT_W-1:0]       integer_part,
	output logic [ubdc_pkg::FRAC_W-1:0]      fractional_part
);
	import ubdc_pkg::*;

	logic [QUO_W:0]   r8_full;
	logic [QUO_W-1:0] r16_full;
	logic [RND_W-1:0] r8;
	logic [RND_W-1:0] r16;
	logic [RND_W-1:0] chosen;
	logic             hs;
	logic             err;

	always_comb begin
		r8_full  = ({1'b0, in_data.quo} + {{QUO_W{1'b0}}, 1'b1}) >> 1;
		r16_full = ({1'b0, in_data.quo[QUO_W-1:1]} + {{(QUO_W-1){1'b0}}, 1'b1}) >> 1;
		r8       = r8_full[RND_W-1:0];
		r16      = r16_full[RND_W-1:0];
		err      = in_data.zero || (in_data.force16 && in_data.too_large);
		if (in_data.force16 || (r16[FRAC_W-1:0] < r8[FRAC_W-1:0])) begin
			chosen = r16;
			hs     = 1'b0;
		end else begin
			chosen = r8;
			hs     = 1'b1;
		end
		if (err) begin
			chosen = '0;
			hs     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status          <= err;
			high_speed      <= hs;
			integer_part    <= chosen[RND_W-1:FRAC_W];
			fractional_part <= chosen[FRAC_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: sv/uart_baud_divisor_calc.sv
// Top level of the UART baud divisor calculator: configuration registers,
// front stages, the divider pipeline and the output stage.
// Depends on ubdc_pkg, ubdc_div_step and ubdc_round_select.
//
//   Channel   Direction  Contents
//   s_axis    in         baud rate request
//   m_axis    out        status, oversampling choice and divisor
//   cfg       in         register writes, no read-back
//
// The pipeline has three front stages, 24 division stages (one quotient
// bit each) and the output register. A new request may enter every cycle
// while not stalled: all stages advance together whenever the output
// register is empty or is being taken, so a stall holds every request in
// place. Reset clears the valid bits and restores the register defaults.
`default_nettype none
module uart_baud_divisor_calc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [ubdc_pkg::BAUD_W-1:0]   s_axis_tdata,   // [23:0] baud_rate
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [ubdc_pkg::ODATA_W-1:0]       m_axis_tdata,   // [0] high_speed,
	                                                           // [16:1] integer_part,
	                                                           // [22:17] fractional_part
	output logic                               m_axis_tuser,   // [0] status
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [ubdc_pkg::CLK_W-1:0]    cfg_data
);
	import ubdc_pkg::*;

	logic              clock_source_q;
	logic [CLK_W-1:0]  system_clock_q;
	logic              smart_card_q;

	logic              adv;

	logic              valid_s1;
	logic [BAUD_W-1:0] baud_s1;
	logic [CLK_W-1:0]  clk_s1;
	logic              smart_s1;

	logic              valid_s2;
	logic [BAUD_W-1:0] baud_s2;
	logic [CLK_W-1:0]  clk_s2;
	logic              smart_s2;
	logic [MUL_W-1:0]  mul_s2;

	logic              valid_s3;
	div_t              div_s3;
	div_t              div_in;

	logic              div_v [QUO_W+1];
	div_t              div_d [QUO_W+1];

	logic              status;
	logic              high_speed;
	logic [INT_W-1:0]  integer_part;
	logic [FRAC_W-1:0] fractional_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_source_q <= 1'b0;
			system_clock_q <= SYS_CLOCK_RESET;
			smart_card_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLOCK_SOURCE: clock_source_q <= cfg_data[0];
				CFG_SYSTEM_CLOCK: system_clock_q <= cfg_data;
				CFG_SMART_CARD:   smart_card_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		div_in           = '0;
		div_in.zero      = (baud_s2 == '0);
		div_in.force16   = ({{(CMP_W-CLK_W){1'b0}}, clk_s2} > {1'b0, mul_s2, 3'b000})
		                   || smart_s2;
		div_in.too_large = ({{(CMP_W-CLK_W){1'b0}}, clk_s2} > {mul_s2, 4'b0000});
		div_in.baud      = baud_s2;
		div_in.num       = {clk_s2, 4'b0000};
		div_in.rem       = {{(REM_W-(NUM_W-QUO_W)){1'b0}}, clk_s2[CLK_W-1:QUO_W-4]};
		div_in.quo       = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			baud_s1  <= s_axis_tdata;
			clk_s1   <= clock_source_q ? system_clock_q : FIXED_CLOCK_HZ;
			smart_s1 <= smart_card_q;
			baud_s2  <= baud_s1;
			clk_s2   <= clk_s1;
			smart_s2 <= smart_s1;
			mul_s2   <= {baud_s1, 16'h0000} - {16'h0000, baud_s1};
			div_s3   <= div_in;
		end
	end

	assign div_v[0] = valid_s3;
	assign div_d[0] = div_s3;

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		ubdc_div_step #(
			.BIT (QUO_W - 1 - g)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (div_v[g]),
			.in_data   (div_d[g]),
			.out_valid (div_v[g+1]),
			.out_data  (div_d[g+1])
		);
	end

	ubdc_round_select u_select (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (adv),
		.in_valid        (div_v[QUO_W]),
		.in_data         (div_d[QUO_W]),
		.out_valid       (m_axis_tvalid),
		.status          (status),
		.high_speed      (high_speed),
		.integer_part    (integer_part),
		.fractional_part (fractional_part)
	);

	assign m_axis_tuser = status;
	assign m_axis_tdata = {1'b0, fractional_part, integer_part, high_speed};

	a_error_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error result carries a non-zero divisor");

	a_first_stage_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv) && valid_s1 |-> $past(s_axis_tvalid))
		else $error("first stage valid without an accepted request");

	a_stall_freezes_front: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s1) && $stable(valid_s3))
		else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
